// File: hdl/fcfp_pkg.sv
package fcfp_pkg;

  localparam int DEF_MAX_PAYLOAD  = 256;
  localparam int DEF_FLASH_BYTES  = 16777216;
  localparam int DEF_SECTOR_BYTES = 4096;
  localparam int DEF_BLOCK_BYTES  = 65536;

  localparam logic [2:0] HEADER_SIZE = 3'd7;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_PROCESS = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] RK_NONE    = 2'd0;
  localparam logic [1:0] RK_DESC    = 2'd1;
  localparam logic [1:0] RK_PAYLOAD = 2'd2;

  localparam logic [2:0] CK_UNKNOWN = 3'd0;
  localparam logic [2:0] CK_READ    = 3'd1;
  localparam logic [2:0] CK_WRITE   = 3'd2;
  localparam logic [2:0] CK_SECTOR  = 3'd3;
  localparam logic [2:0] CK_BLOCK   = 3'd4;
  localparam logic [2:0] CK_CHIP_ID = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;
  localparam logic [1:0] ST_UNKNOWN  = 2'd3;

  localparam logic [2:0] CFG_MAGIC     = 3'd0;
  localparam logic [2:0] CFG_OPC_READ  = 3'd1;
  localparam logic [2:0] CFG_OPC_WRITE = 3'd2;
  localparam logic [2:0] CFG_OPC_SE    = 3'd3;
  localparam logic [2:0] CFG_OPC_ID    = 3'd4;
  localparam logic [2:0] CFG_OPC_BE    = 3'd5;
  localparam logic [2:0] CFG_CHIP_ID   = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  cmd;
    logic [1:0]  status;
    logic [23:0] address;
    logic [15:0] length;
    logic [31:0] data_word;
    logic        assembling;
  } res_t;

endpackage

// File: hdl/flash_command_frame_parser.sv
// Flash command frame parser.
// Input channel in_*: one beat per item. in_tuser carries the op (received byte,
// process pending frame, read payload byte); in_tdata carries rx_byte and
// payload_index. Output channel out_*: exactly one beat per input beat, in order;
// out_tuser is the result kind, out_tdata the descriptor / payload fields.
// Configuration port cfg_*: write-only, one register per cycle, used while idle.
// Frame bytes go to a header register file; payload bytes go to a single-port
// synchronous payload memory (one entry per write beat, registered read).
// Throughput: one beat per cycle for every op, as long as out_tready stays high.
// A result passes through stage 1, beside the payload memory read register, and
// then through the output register before it is offered.
// When the receiver stalls, the output register holds and the stage behind it
// fills; in_tready drops only once both are full, so no beat is lost.
// Reset (rst_n low, synchronous): assembler returns to idle, counts cleared,
// registers take their defaults, both pipeline stages empty. The payload memory
// is not cleared and needs no clearing pass; unwritten entries read as junk.
// Erase granules are fixed at 4 KiB (sector) and 64 KiB (block).
module flash_command_frame_parser import fcfp_pkg::*; #(
  parameter int MAX_PAYLOAD  = DEF_MAX_PAYLOAD,
  parameter int FLASH_BYTES  = DEF_FLASH_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [15:8] payload_index
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [2:0] command_kind, [4:3] status, [28:5] address,
                                  // [44:29] length, [76:45] data_word, [77] assembling
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [24:0] FLASH_LIM   = 25'(FLASH_BYTES);
  localparam logic [23:0] SECTOR_MASK = 24'(DEF_SECTOR_BYTES - 1);
  localparam logic [23:0] BLOCK_MASK  = 24'(DEF_BLOCK_BYTES - 1);
  localparam logic [16:0] MAX_LEN     = 17'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_DATA    = 4'b0100,
    PH_PENDING = 4'b1000
  } phase_t;

  // configuration
  logic [7:0]  magic_r, opc_rd_r, opc_wr_r, opc_se_r, opc_id_r, opc_be_r;
  logic [31:0] chip_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= 8'd0;
      opc_rd_r  <= 8'd1;
      opc_wr_r  <= 8'd2;
      opc_se_r  <= 8'd3;
      opc_id_r  <= 8'd4;
      opc_be_r  <= 8'd5;
      chip_id_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAGIC:     magic_r   <= cfg_wdata[7:0];
        CFG_OPC_READ:  opc_rd_r  <= cfg_wdata[7:0];
        CFG_OPC_WRITE: opc_wr_r  <= cfg_wdata[7:0];
        CFG_OPC_SE:    opc_se_r  <= cfg_wdata[7:0];
        CFG_OPC_ID:    opc_id_r  <= cfg_wdata[7:0];
        CFG_OPC_BE:    opc_be_r  <= cfg_wdata[7:0];
        CFG_CHIP_ID:   chip_id_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input side
  logic       acc;
  logic [1:0] in_op;
  logic [7:0] in_byte, in_idx;
  logic       in_range;

  assign in_op    = in_tuser;
  assign in_byte  = in_tdata[7:0];
  assign in_idx   = in_tdata[15:8];
  assign acc      = in_tvalid && in_tready;
  assign in_range = (32'(in_idx) < MAX_PAYLOAD);

  // assembler state
  phase_t          phase_r, phase_nxt;
  logic [2:0]      hcnt_r, hcnt_nxt;
  logic [CW-1:0]   pcnt_r, pcnt_nxt;
  logic [15:0]     plen_r, plen_nxt;
  logic [7:0]      header_r [HEADER_SIZE];
  logic            hdr_we;
  logic [2:0]      hdr_wa;
  logic            mem_we;
  logic [7:0]      pay_mem [MAX_PAYLOAD];
  logic [7:0]      pay_q_r;

  // descriptor from header
  logic [23:0] h_addr;
  logic [15:0] h_len, new_len;
  logic [24:0] h_end;
  logic [1:0]  xfer_st, se_st, be_st;
  res_t        desc;
  res_t        res0;
  logic        rd0;
  logic [16:0] pcnt_inc;

  assign h_addr  = {header_r[2], header_r[3], header_r[4]};
  assign h_len   = {header_r[5], header_r[6]};
  assign new_len = {header_r[5], in_byte};
  assign h_end   = {1'b0, h_addr} + 25'(h_len);

  always_comb begin
    if (h_len == 16'd0 || {1'b0, h_len} > MAX_LEN) begin
      xfer_st = ST_BAD_LEN;
    end else if (h_end > FLASH_LIM) begin
      xfer_st = ST_BAD_ADDR;
    end else begin
      xfer_st = ST_OK;
    end
    se_st = ((h_addr & SECTOR_MASK) != 24'd0 || {1'b0, h_addr} >= FLASH_LIM) ?
            ST_BAD_ADDR : ST_OK;
    be_st = ((h_addr & BLOCK_MASK) != 24'd0 || {1'b0, h_addr} >= FLASH_LIM) ?
            ST_BAD_ADDR : ST_OK;

    desc            = '0;
    desc.kind       = RK_DESC;
    desc.address    = h_addr;
    desc.length     = h_len;
    desc.cmd        = CK_UNKNOWN;
    desc.status     = ST_UNKNOWN;
    if (header_r[1] == opc_rd_r) begin
      desc.cmd    = CK_READ;
      desc.status = xfer_st;
    end else if (header_r[1] == opc_wr_r) begin
      desc.cmd    = CK_WRITE;
      desc.status = xfer_st;
    end else if (header_r[1] == opc_se_r) begin
      desc.cmd    = CK_SECTOR;
      desc.status = se_st;
    end else if (header_r[1] == opc_id_r) begin
      desc.cmd       = CK_CHIP_ID;
      desc.status    = ST_OK;
      desc.data_word = chip_id_r;
    end else if (header_r[1] == opc_be_r) begin
      desc.cmd    = CK_BLOCK;
      desc.status = be_st;
    end
  end

  assign pcnt_inc = {1'b0, 16'(pcnt_r)} + 17'd1;

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    pcnt_nxt  = pcnt_r;
    plen_nxt  = plen_r;
    hdr_we    = 1'b0;
    hdr_wa    = hcnt_r;
    mem_we    = 1'b0;
    res0      = '0;
    rd0       = 1'b0;
    if (acc) begin
      case (in_op)
        OP_BYTE: begin
          case (phase_r)
            PH_IDLE: begin
              if (in_byte == magic_r) begin
                hdr_we    = 1'b1;
                hdr_wa    = 3'd0;
                hcnt_nxt  = 3'd1;
                phase_nxt = PH_HEADER;
              end
            end
            PH_HEADER: begin
              hdr_we   = 1'b1;
              hcnt_nxt = hcnt_r + 3'd1;
              if (hcnt_r == HEADER_SIZE - 3'd1) begin
                pcnt_nxt = '0;
                plen_nxt = new_len;
                if (header_r[1] == opc_wr_r && new_len != 16'd0) begin
                  if ({1'b0, new_len} > MAX_LEN) begin
                    phase_nxt = PH_IDLE;
                    hcnt_nxt  = 3'd0;
                    plen_nxt  = 16'd0;
                  end else begin
                    phase_nxt = PH_DATA;
                  end
                end else begin
                  phase_nxt = PH_PENDING;
                end
              end
            end
            PH_DATA: begin
              mem_we   = 1'b1;
              pcnt_nxt = pcnt_r + CW'(1);
              if (pcnt_inc >= {1'b0, plen_r}) begin
                phase_nxt = PH_PENDING;
              end
            end
            default: ;
          endcase
        end
        OP_PROCESS: begin
          if (phase_r == PH_PENDING) begin
            res0      = desc;
            phase_nxt = PH_IDLE;
            hcnt_nxt  = 3'd0;
            pcnt_nxt  = '0;
            plen_nxt  = 16'd0;
          end
        end
        OP_READ: begin
          res0.kind = RK_PAYLOAD;
          rd0       = 1'b1;
        end
        default: ;
      endcase
    end
    res0.assembling = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hcnt_r  <= 3'd0;
      pcnt_r  <= '0;
      plen_r  <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      pcnt_r  <= pcnt_nxt;
      plen_r  <= plen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      header_r[hdr_wa] <= in_byte;
    end
  end

  // payload memory: one write or one read per beat, never both
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pay_mem[PW'(pcnt_r)] <= in_byte;
    end
    if (acc && rd0) begin
      pay_q_r <= pay_mem[PW'(in_idx)];
    end
  end

  // stage 1 and output register
  logic s1_v_r, s1_rd_r, s1_inr_r, s1_move;
  res_t s1_res_r, s1_out;
  logic out_v_r;
  res_t out_res_r;

  assign s1_move   = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_move;

  always_comb begin
    s1_out = s1_res_r;
    if (s1_rd_r) begin
      s1_out.data_word = s1_inr_r ? {24'd0, pay_q_r} : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_v_r <= acc;
      end
      if (s1_move) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r <= res0;
      s1_rd_r  <= rd0;
      s1_inr_r <= in_range;
    end
    if (s1_move && s1_v_r) begin
      out_res_r <= s1_out;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {2'b00, out_res_r.assembling, out_res_r.data_word,
                       out_res_r.length, out_res_r.address, out_res_r.status,
                       out_res_r.cmd};

`ifndef SYNTH
  a_data_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (32'(pcnt_r) < MAX_PAYLOAD && plen_r != 16'd0))
    else $error("payload count out of range in data phase");

  a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (hcnt_r != 3'd0 && hcnt_r < HEADER_SIZE))
    else $error("header count out of range in header phase");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.kind == RK_PAYLOAD) |->
      (out_res_r.data_word[31:8] == 24'd0 && out_res_r.address == 24'd0 &&
       out_res_r.length == 16'd0 && out_res_r.cmd == CK_UNKNOWN))
    else $error("payload beat carries descriptor bits");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_move) |=> (s1_v_r && $stable(s1_res_r)))
    else $error("stage 1 lost while output stalled");

  a_sector_align: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.kind == RK_DESC && out_res_r.cmd == CK_SECTOR &&
     out_res_r.status == ST_OK) |-> ((out_res_r.address & SECTOR_MASK) == 24'd0))
    else $error("misaligned sector erase reported ok");
`endif

endmodule
